>>> design/bve_pkg.sv
// ----------------------------------------------------------------------------
// bve_pkg
// Shared types, character codes and the byte classifier for the visible
// escape encoder.
// ----------------------------------------------------------------------------
package bve_pkg;

  // Character codes used by the escape sequences.
  localparam logic [7:0] ChEsc    = 8'd27;
  localparam logic [7:0] ChBs     = 8'd8;
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChNl     = 8'd10;
  localparam logic [7:0] ChFf     = 8'd12;
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChBslash = 8'd92;
  localparam logic [7:0] ChCaret  = 8'd94;
  localparam logic [7:0] ChDel    = 8'd127;
  localparam logic [7:0] ChUpperE = 8'h45;
  localparam logic [7:0] ChLowerN = 8'h6e;
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChQuery  = 8'h3f;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] CtlBit   = 8'h40;

  localparam logic [31:0] CountMax = 32'hffff_ffff;

  // One classified item: up to four characters and the index of the last one.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
  } seq_t;

  // Expands one input item into its visible character sequence.
  function automatic seq_t encode(input logic [7:0] b, input logic eos);
    seq_t s;
    s.chars    = '0;
    s.last_idx = 2'd0;
    if (eos) begin
      s.chars[0] = ChNl;
    end else begin
      unique case (b)
        ChEsc: begin
          s.chars[0] = ChNl;
          s.chars[1] = ChBslash;
          s.chars[2] = ChUpperE;
          s.last_idx = 2'd2;
        end
        ChNl: begin
          s.chars[0] = ChNl;
          s.chars[1] = ChBslash;
          s.chars[2] = ChLowerN;
          s.last_idx = 2'd2;
        end
        ChBs: begin
          s.chars[0] = ChBslash;
          s.chars[1] = ChLowerB;
          s.last_idx = 2'd1;
        end
        ChFf: begin
          s.chars[0] = ChBslash;
          s.chars[1] = ChLowerF;
          s.last_idx = 2'd1;
        end
        ChCr: begin
          s.chars[0] = ChBslash;
          s.chars[1] = ChLowerR;
          s.last_idx = 2'd1;
        end
        ChTab: begin
          s.chars[0] = ChBslash;
          s.chars[1] = ChLowerT;
          s.last_idx = 2'd1;
        end
        ChCaret: begin
          s.chars[0] = ChBslash;
          s.chars[1] = ChCaret;
          s.last_idx = 2'd1;
        end
        ChDel: begin
          s.chars[0] = ChBslash;
          s.chars[1] = ChQuery;
          s.last_idx = 2'd1;
        end
        default: begin
          if (b[7]) begin
            // High bytes become a backslash and three octal digits.
            s.chars[0] = ChBslash;
            s.chars[1] = ChZero + {6'd0, b[7:6]};
            s.chars[2] = ChZero + {5'd0, b[5:3]};
            s.chars[3] = ChZero + {5'd0, b[2:0]};
            s.last_idx = 2'd3;
          end else if (b[6:5] == 2'b00) begin
            // Remaining control bytes use caret notation.
            s.chars[0] = ChCaret;
            s.chars[1] = b | CtlBit;
            s.last_idx = 2'd1;
          end else begin
            s.chars[0] = b;
          end
        end
      endcase
    end
    return s;
  endfunction

endpackage

>>> design/bve_if.sv
// ----------------------------------------------------------------------------
// bve_if
// Valid/ready channel interfaces for raw input bytes and visible characters.
// ----------------------------------------------------------------------------
interface bve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source(output valid, output data_byte, output end_of_stream, input ready);
  modport sink(input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface bve_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        last;
  logic [31:0] chars_written;

  modport source(output valid, output out_char, output last, output chars_written,
                 input ready);
  modport sink(input valid, input out_char, input last, input chars_written,
               output ready);
endinterface

>>> design/bve_front.sv
// ----------------------------------------------------------------------------
// bve_front
// Accepts input bytes, classifies them and holds the resulting character
// sequence in a register until the queue takes it.
// ----------------------------------------------------------------------------
module bve_front
  import bve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bve_in_if.sink byte_stream,
  output logic   push,
  output seq_t   push_seq,
  input  logic   queue_full
);

  logic stg_valid;
  seq_t stg_seq;

  // A held sequence moves on whenever the queue has room.
  assign push     = stg_valid && !queue_full;
  assign push_seq = stg_seq;

  assign byte_stream.ready = !stg_valid || push;

  // Stage valid follows input transfers and queue writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      stg_valid <= byte_stream.valid;
    end
  end

  // Classify at the input transfer.
  always_ff @(posedge clk) begin
    if (byte_stream.valid && byte_stream.ready) begin
      stg_seq <= encode(byte_stream.data_byte, byte_stream.end_of_stream);
    end
  end

endmodule

>>> design/bve_queue.sv
// ----------------------------------------------------------------------------
// bve_queue
// Two-entry queue of classified sequences between front and back.
// ----------------------------------------------------------------------------
module bve_queue
  import bve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  seq_t push_seq,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output seq_t head_seq
);

  seq_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_seq   = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_seq;
    end
  end

endmodule

>>> design/bve_back.sv
// ----------------------------------------------------------------------------
// bve_back
// Walks the head sequence one character per cycle, while the output is not stalled, into
// an output register and keeps the saturating character count.
// ----------------------------------------------------------------------------
module bve_back
  import bve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  seq_t head_seq,
  output logic pop,
  bve_out_if.source char_stream
);

  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;
  logic [31:0] out_count;
  logic [1:0]  idx;
  logic [31:0] char_total;
  logic [31:0] char_total_next;
  logic        advance;
  logic        emit;
  logic        at_last;

  assign advance = !out_valid || char_stream.ready;
  assign emit    = advance && head_valid;
  assign at_last = (idx == head_seq.last_idx);
  assign pop     = emit && at_last;

  assign char_total_next = (char_total == CountMax) ? char_total : char_total + 32'd1;

  assign char_stream.valid         = out_valid;
  assign char_stream.out_char      = out_char;
  assign char_stream.last          = out_last;
  assign char_stream.chars_written = out_count;

  // Control: output valid, character index and running count.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      idx        <= 2'd0;
      char_total <= '0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (emit) begin
        char_total <= char_total_next;
        idx        <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_char  <= head_seq.chars[idx];
      out_last  <= at_last;
      out_count <= char_total_next;
    end
  end

endmodule

>>> design/byte_visible_escape_encoder_core.sv
// Path: the first character of an item is held in the front stage register, then in a queue
// entry, then in the output register, from which it transfers when the receiver is ready.
// Output: one character per cycle while the receiver is ready; an item expands to 1 to 4
// characters, sent one at a time over the single output character port.
// A two-entry queue lets input transfers continue while the output stalls.
// Reset (rst, synchronous) empties all stages and clears the character count.
// ----------------------------------------------------------------------------
// byte_visible_escape_encoder_core
// Top level: front classifier, sequence queue and character serializer.
// ----------------------------------------------------------------------------
module byte_visible_escape_encoder_core
  import bve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bve_in_if.sink    byte_stream,
  bve_out_if.source char_stream
);

  logic push;
  seq_t push_seq;
  logic queue_full;
  logic pop;
  logic head_valid;
  seq_t head_seq;

  bve_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .push        (push),
    .push_seq    (push_seq),
    .queue_full  (queue_full)
  );

  bve_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_seq   (push_seq),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_seq   (head_seq)
  );

  bve_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_seq    (head_seq),
    .pop         (pop),
    .char_stream (char_stream)
  );

endmodule

>>> dv/tb_byte_visible_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_byte_visible_escape_encoder_core
// Self-checking testbench for the visible escape encoder. Bytes go in over
// the input channel and the visible characters come out over the output
// channel. A predictor in this file expands each accepted byte into its
// expected characters, and a checker compares every output transfer with
// the oldest expected character. The sender idles in bursts and the
// receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_byte_visible_escape_encoder_core;
  import bve_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 12;

  // One expected character on the output channel.
  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic [31:0] count;
  } visible_char_t;

  logic clk;
  logic rst;
  logic out_ready;

  bve_in_if  byte_if();
  bve_out_if char_if();

  assign char_if.ready = out_ready;

  byte_visible_escape_encoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .char_stream (char_if)
  );

  visible_char_t pending_chars[$];
  logic [31:0]   char_total;
  int            fail_count;
  int            items_sent;
  int            eos_sent;
  int            chars_checked;
  int            burst_left;
  bit            gaps_enabled;
  int            idle_cycles;
  logic [15:0]   ready_pattern;
  int            pattern_age;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Expands one accepted item into the characters the encoder must produce.
  function automatic void predict_visible_form(input logic [7:0] b, input logic eos);
    logic [7:0]    seq [4];
    int            n;
    visible_char_t entry;
    n = 0;
    if (eos) begin
      seq[0] = ChNl;
      n = 1;
    end else if (b == ChEsc) begin
      seq[0] = ChNl; seq[1] = ChBslash; seq[2] = ChUpperE;
      n = 3;
    end else if (b == ChNl) begin
      seq[0] = ChNl; seq[1] = ChBslash; seq[2] = ChLowerN;
      n = 3;
    end else if (b == ChBs) begin
      seq[0] = ChBslash; seq[1] = ChLowerB;
      n = 2;
    end else if (b == ChFf) begin
      seq[0] = ChBslash; seq[1] = ChLowerF;
      n = 2;
    end else if (b == ChCr) begin
      seq[0] = ChBslash; seq[1] = ChLowerR;
      n = 2;
    end else if (b == ChTab) begin
      seq[0] = ChBslash; seq[1] = ChLowerT;
      n = 2;
    end else if (b == ChCaret) begin
      seq[0] = ChBslash; seq[1] = ChCaret;
      n = 2;
    end else if (b == ChDel) begin
      seq[0] = ChBslash; seq[1] = ChQuery;
      n = 2;
    end else if (b >= 8'd128) begin
      // Backslash and three octal digits, most significant first.
      seq[0] = ChBslash;
      seq[1] = ChZero + {6'd0, b[7:6]};
      seq[2] = ChZero + {5'd0, b[5:3]};
      seq[3] = ChZero + {5'd0, b[2:0]};
      n = 4;
    end else if (b < 8'd32) begin
      seq[0] = ChCaret; seq[1] = b | CtlBit;
      n = 2;
    end else begin
      seq[0] = b;
      n = 1;
    end
    // The running count saturates at its maximum.
    for (int k = 0; k < n; k++) begin
      if (char_total != CountMax) char_total = char_total + 32'd1;
      entry.ch    = seq[k];
      entry.last  = (k == n - 1);
      entry.count = char_total;
      pending_chars.push_back(entry);
    end
  endfunction

  // Picks a byte with a bias toward the classes that expand.
  function automatic logic [7:0] pick_random_byte();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return 8'($urandom_range(0, 31));
    if (sel < 50) return 8'($urandom_range(128, 255));
    if (sel < 55) return ($urandom_range(0, 1) != 0) ? ChDel : ChCaret;
    return 8'($urandom_range(32, 126));
  endfunction

  // Sends one item and waits for its transfer, inserting a random gap
  // between bursts when gaps are enabled.
  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_enabled ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    byte_if.valid         <= 1'b1;
    byte_if.data_byte     <= b;
    byte_if.end_of_stream <= eos;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    predict_visible_form(b, eos);
    items_sent++;
    if (eos) eos_sent++;
    burst_left--;
  endtask

  // Every escape form, caret notation, octal form, pass-through and the
  // end-of-stream marker, including encoding resumed after a marker.
  task automatic test_escape_table();
    gaps_enabled = 1'b1;
    send_item(ChEsc, 1'b0);
    send_item(ChNl, 1'b0);
    send_item(ChBs, 1'b0);
    send_item(ChFf, 1'b0);
    send_item(ChCr, 1'b0);
    send_item(ChTab, 1'b0);
    send_item(ChCaret, 1'b0);
    send_item(ChDel, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h1f, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h7e, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(ChEsc, 1'b0);
    send_item(8'h03, 1'b0);
  endtask

  // Random text with occasional end-of-stream markers, sender idling on.
  task automatic test_random_stream(input int count);
    gaps_enabled = 1'b1;
    repeat (count) begin
      send_item(pick_random_byte(), ($urandom_range(0, 9) == 0));
    end
  endtask

  // Back-to-back items with no sender gaps, so the queue fills under stalls.
  task automatic test_full_rate_stream(input int count);
    gaps_enabled = 1'b0;
    burst_left   = 0;
    repeat (count) begin
      send_item(pick_random_byte(), ($urandom_range(0, 14) == 0));
    end
  endtask

  // Receiver stall pattern: rotates, and is reloaded now and then, sometimes
  // with a pattern that never stalls.
  always @(posedge clk) begin
    if (pattern_age == 0) begin
      if ($urandom_range(0, 3) == 0) ready_pattern = 16'hffff;
      else ready_pattern = 16'($urandom) | 16'h0001;
      pattern_age = $urandom_range(20, 80);
    end else begin
      pattern_age--;
    end
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    out_ready <= ready_pattern[0];
  end

  // Output checker: each transfer against the oldest expected character.
  always @(posedge clk) begin
    visible_char_t want;
    if (!rst && char_if.valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $error("out_char: expected none, actual 0x%02h", char_if.out_char);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (char_if.out_char !== want.ch) begin
          $error("out_char: expected 0x%02h, actual 0x%02h", want.ch, char_if.out_char);
          fail_count++;
        end
        if (char_if.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, char_if.last);
          fail_count++;
        end
        if (char_if.chars_written !== want.count) begin
          $error("chars_written: expected %0d, actual %0d", want.count,
                 char_if.chars_written);
          fail_count++;
        end
        chars_checked++;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (byte_if.valid && byte_if.ready) || (char_if.valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired with %0d characters outstanding.", pending_chars.size());
        $display("byte_visible_escape_encoder_core: mismatch");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst                   = 1'b1;
    byte_if.valid         = 1'b0;
    byte_if.data_byte     = 8'h00;
    byte_if.end_of_stream = 1'b0;
    out_ready             = 1'b0;
    ready_pattern         = 16'hffff;
    pattern_age           = 0;
    idle_cycles           = 0;
    char_total            = 32'd0;
    fail_count            = 0;
    items_sent            = 0;
    eos_sent              = 0;
    chars_checked         = 0;
    burst_left            = 0;
    gaps_enabled          = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_escape_table();
    test_random_stream(71);
    test_full_rate_stream(30);

    byte_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d items (%0d end-of-stream markers): escapes, caret, octal, plain.",
             items_sent, eos_sent);
    $display("Checked %0d output characters under sender gaps and receiver stalls.",
             chars_checked);
    if (fail_count == 0) begin
      $display("byte_visible_escape_encoder_core: match");
    end else begin
      $display("byte_visible_escape_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/bve_pkg.sv
design/bve_if.sv
design/bve_front.sv
design/bve_queue.sv
design/bve_back.sv
design/byte_visible_escape_encoder_core.sv
dv/tb_byte_visible_escape_encoder_core.sv
